// File: src/tga_pkg.sv
// ----------------------------------------------------------------------------
// Tensor grouped address generator package
// Shared constants, function codes and structures of the address generator.
// ----------------------------------------------------------------------------
package tga_pkg;

    localparam int AXES       = 4;
    localparam int COORD_W    = 16;
    localparam int ADDR_W     = 48;
    localparam int GROUPS     = 8;
    localparam int GRP_W      = 3;
    localparam int ROWS       = 64;
    localparam int ROW_W      = 6;
    localparam int REMAP_W    = 16;
    localparam int LEN_W      = 7;
    localparam int ELEM_W     = 5;
    localparam int STRIDE_W   = 32;
    localparam int CNT_W      = 3;
    localparam int GCNT_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    localparam logic [1:0] FUNC_XLATE = 2'd0;
    localparam logic [1:0] FUNC_BASE  = 2'd1;
    localparam logic [1:0] FUNC_REMAP = 2'd2;
    localparam logic [1:0] FUNC_LEN   = 2'd3;

    localparam logic [1:0] PATH_FLAT  = 2'd0;
    localparam logic [1:0] PATH_GROUP = 2'd1;
    localparam logic [1:0] PATH_OVF   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GMODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAXIS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAXIS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GCOUNT = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]     base_address;
        logic [CNT_W-1:0]      tensor_rank;
        logic [63:0]           dim_sizes;
        logic                  group_mode;
        logic [1:0]            gaxis;
        logic [1:0]            raxis;
        logic [STRIDE_W-1:0]   row_stride;
        logic [GCNT_W-1:0]     group_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                     path;
        logic [ADDR_W-1:0]              base;
        logic [REMAP_W-1:0]             prow;
        logic [AXES-1:0][COORD_W-1:0]   coord;
        logic [AXES-1:0][COORD_W-1:0]   size;
        logic [ELEM_W-1:0]              elem;
        logic [STRIDE_W-1:0]            stride;
        logic                           stride_zero;
    } t_job;

    typedef struct packed {
        t_job              job;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] dense;
    } t_stage;

endpackage

// File: src/tga_fifo.sv
// ----------------------------------------------------------------------------
// Job queue
// Short queue that decouples the classifying front end from the datapath.
// ----------------------------------------------------------------------------
module tga_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tga_pkg::t_job i_data,
    input  logic          i_pop,
    output tga_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import tga_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: src/tga_front.sv
// ----------------------------------------------------------------------------
// Address generator front end
// Accepts items, performs table writes, reads the tables and classifies
// each translation into a job for the datapath.
// ----------------------------------------------------------------------------
module tga_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tga_pkg::t_cfg                     i_cfg,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_func,
    input  logic [tga_pkg::COORD_W-1:0]       i_coord0,
    input  logic [tga_pkg::COORD_W-1:0]       i_coord1,
    input  logic [tga_pkg::COORD_W-1:0]       i_coord2,
    input  logic [tga_pkg::COORD_W-1:0]       i_coord3,
    input  logic [tga_pkg::CNT_W-1:0]         i_coord_count,
    input  logic [tga_pkg::ELEM_W-1:0]        i_element_bytes,
    input  logic [tga_pkg::GRP_W-1:0]         i_table_group,
    input  logic [tga_pkg::ROW_W-1:0]         i_table_row,
    input  logic [tga_pkg::ADDR_W-1:0]        i_write_value,
    output logic                              o_push,
    output tga_pkg::t_job                     o_job,
    input  logic                              i_q_full
);
    import tga_pkg::*;

    logic [ADDR_W-1:0]  r_gbase [GROUPS];
    logic [REMAP_W-1:0] r_remap [GROUPS*ROWS];
    logic [LEN_W-1:0]   r_len   [GROUPS];

    logic                         r_s1_valid;
    logic [AXES-1:0][COORD_W-1:0] r_coord;
    logic [CNT_W-1:0]             r_count;
    logic [ELEM_W-1:0]            r_elem;
    logic [REMAP_W-1:0]           r_rd;

    logic                         w_accept;
    logic [AXES-1:0][COORD_W-1:0] w_in_coord;
    logic [GRP_W+ROW_W-1:0]       w_raddr;
    logic [CNT_W-1:0]             w_n;
    logic [CNT_W-1:0]             w_rank;
    logic [GCNT_W-1:0]            w_gc;
    logic                         w_flat;
    logic [COORD_W-1:0]           w_grp;
    logic [COORD_W-1:0]           w_lrow;
    logic                         w_ovf;
    logic [GRP_W-1:0]             w_gi;

    assign o_stall  = r_s1_valid && i_q_full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_s1_valid && !i_q_full;

    assign w_in_coord = {i_coord3, i_coord2, i_coord1, i_coord0};
    assign w_raddr = {w_in_coord[i_cfg.gaxis][GRP_W-1:0],
                      w_in_coord[i_cfg.raxis][ROW_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_accept && i_func == FUNC_BASE) begin
            r_gbase[i_table_group] <= i_write_value;
        end
        if (w_accept && i_func == FUNC_REMAP) begin
            r_remap[{i_table_group, i_table_row}] <= i_write_value[REMAP_W-1:0];
        end
        if (w_accept) begin
            r_rd    <= r_remap[w_raddr];
            r_coord <= w_in_coord;
            r_count <= i_coord_count;
            r_elem  <= i_element_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int g = 0; g < GROUPS; g++) begin
                r_len[g] <= '0;
            end
        end else begin
            if (!o_stall) begin
                r_s1_valid <= w_accept && (i_func == FUNC_XLATE);
            end
            if (w_accept && i_func == FUNC_LEN) begin
                r_len[i_table_group] <= (i_write_value > ADDR_W'(ROWS))
                                        ? LEN_W'(ROWS) : i_write_value[LEN_W-1:0];
            end
        end
    end

    always_comb begin
        w_n    = (r_count > CNT_W'(AXES)) ? CNT_W'(AXES) : r_count;
        w_rank = (i_cfg.tensor_rank > CNT_W'(AXES)) ? CNT_W'(AXES) : i_cfg.tensor_rank;
        w_gc   = (i_cfg.group_count > GCNT_W'(GROUPS)) ? GCNT_W'(GROUPS)
                                                       : i_cfg.group_count;
        w_flat = !i_cfg.group_mode || (w_n != w_rank)
                 || (CNT_W'(i_cfg.gaxis) >= w_n) || (CNT_W'(i_cfg.raxis) >= w_n);
        w_grp  = r_coord[i_cfg.gaxis];
        w_lrow = r_coord[i_cfg.raxis];
        w_ovf  = (w_grp >= COORD_W'(w_gc));
        w_gi   = w_grp[GRP_W-1:0];

        o_job.elem        = r_elem;
        o_job.stride      = i_cfg.row_stride;
        o_job.stride_zero = (i_cfg.row_stride == '0);
        o_job.prow        = '0;
        o_job.base        = i_cfg.base_address;
        o_job.path        = PATH_FLAT;
        for (int d = 0; d < AXES; d++) begin
            o_job.coord[d] = '0;
            o_job.size[d]  = COORD_W'(1);
        end

        if (w_flat) begin
            for (int d = 0; d < AXES; d++) begin
                if (CNT_W'(d) < w_n) begin
                    o_job.coord[d] = r_coord[d];
                    o_job.size[d]  = i_cfg.dim_sizes[63-COORD_W*d -: COORD_W];
                end
            end
        end else if (w_ovf) begin
            o_job.path = PATH_OVF;
        end else begin
            o_job.path = PATH_GROUP;
            o_job.base = r_gbase[w_gi];
            o_job.prow = (w_lrow < COORD_W'(r_len[w_gi])) ? r_rd : w_lrow;
            for (int d = 0; d < AXES; d++) begin
                if (CNT_W'(d) < w_n && 2'(d) != i_cfg.gaxis
                    && 2'(d) != i_cfg.raxis) begin
                    o_job.coord[d] = r_coord[d];
                    if (i_cfg.dim_sizes[63-COORD_W*d -: COORD_W] != '0) begin
                        o_job.size[d] = i_cfg.dim_sizes[63-COORD_W*d -: COORD_W];
                    end
                end
            end
        end
    end

endmodule

// File: src/tga_back.sv
// ----------------------------------------------------------------------------
// Address generator datapath
// Pipelined Horner evaluation of the inner offset and dense row size,
// followed by the scaling products and the final address sum.
// ----------------------------------------------------------------------------
module tga_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tga_pkg::t_job               i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tga_pkg::ADDR_W-1:0]  o_address,
    output logic [1:0]                  o_path_taken
);
    import tga_pkg::*;

    t_stage            r_st [AXES];
    logic [AXES-1:0]   r_v;
    logic              r_mv;
    logic [1:0]        r_mpath;
    logic [ADDR_W-1:0] r_mbase;
    logic [ADDR_W-1:0] r_prod_row;
    logic [ADDR_W-1:0] r_prod_in;
    logic              r_ov;
    logic [ADDR_W-1:0] r_addr;
    logic [1:0]        r_path;

    logic              w_en;
    t_stage            w_src [AXES];
    t_stage            w_nxt [AXES];
    logic [ADDR_W-1:0] w_stride;

    assign w_en         = !r_ov || !i_stall;
    assign o_pop        = w_en && !i_empty;
    assign o_valid      = r_ov;
    assign o_address    = r_addr;
    assign o_path_taken = r_path;

    always_comb begin
        w_src[0].job   = i_head;
        w_src[0].off   = '0;
        w_src[0].dense = ADDR_W'(i_head.elem);
        for (int i = 1; i < AXES; i++) begin
            w_src[i] = r_st[i-1];
        end
        for (int i = 0; i < AXES; i++) begin
            w_nxt[i]       = w_src[i];
            w_nxt[i].off   = ADDR_W'(w_src[i].off * ADDR_W'(w_src[i].job.size[i]))
                             + ADDR_W'(w_src[i].job.coord[i]);
            w_nxt[i].dense = ADDR_W'(w_src[i].dense * ADDR_W'(w_src[i].job.size[i]));
        end
        w_stride = r_st[AXES-1].job.stride_zero ? r_st[AXES-1].dense
                                                : ADDR_W'(r_st[AXES-1].job.stride);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < AXES; i++) begin
                r_st[i] <= w_nxt[i];
            end
            r_mpath    <= r_st[AXES-1].job.path;
            r_mbase    <= r_st[AXES-1].job.base;
            r_prod_row <= ADDR_W'(ADDR_W'(r_st[AXES-1].job.prow) * w_stride);
            r_prod_in  <= ADDR_W'(r_st[AXES-1].off * ADDR_W'(r_st[AXES-1].job.elem));
            r_addr     <= r_mbase + r_prod_row + r_prod_in;
            r_path     <= r_mpath;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v  <= {r_v[AXES-2:0], !i_empty};
            r_mv <= r_v[AXES-1];
            r_ov <= r_mv;
        end
    end

endmodule

// File: src/tensor_grouped_address_generator.sv
// ----------------------------------------------------------------------------
// Tensor grouped address generator
// Translates coordinate vectors into flat or grouped byte addresses.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle unless o_stall is high. Table
// writes take effect at the edge that accepts them and produce no transfer.
// A translation is registered in the front end, which reads the remap memory
// and classifies it, then in the job queue, and then in the datapath, where
// four multiply stages evaluate the inner offset and dense row size and two
// more scale and sum them before the result transfer. A four-entry queue lets
// the front end keep accepting while the output is stalled; once it is full
// the input stalls, and while full the queue takes no push even in a cycle in
// which the datapath pops it. Configuration writes are always ready.
module tensor_grouped_address_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tga_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tga_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_func,
    input  logic [tga_pkg::COORD_W-1:0]       i_coord0,
    input  logic [tga_pkg::COORD_W-1:0]       i_coord1,
    input  logic [tga_pkg::COORD_W-1:0]       i_coord2,
    input  logic [tga_pkg::COORD_W-1:0]       i_coord3,
    input  logic [tga_pkg::CNT_W-1:0]         i_coord_count,
    input  logic [tga_pkg::ELEM_W-1:0]        i_element_bytes,
    input  logic [tga_pkg::GRP_W-1:0]         i_table_group,
    input  logic [tga_pkg::ROW_W-1:0]         i_table_row,
    input  logic [tga_pkg::ADDR_W-1:0]        i_write_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tga_pkg::ADDR_W-1:0]        o_address,
    output logic [1:0]                        o_path_taken
);
    import tga_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_head;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE:   r_cfg.base_address <= i_cfg_data[ADDR_W-1:0];
                CFG_RANK:   r_cfg.tensor_rank  <= i_cfg_data[CNT_W-1:0];
                CFG_DIMS:   r_cfg.dim_sizes    <= i_cfg_data;
                CFG_GMODE:  r_cfg.group_mode   <= i_cfg_data[0];
                CFG_GAXIS:  r_cfg.gaxis        <= i_cfg_data[1:0];
                CFG_RAXIS:  r_cfg.raxis        <= i_cfg_data[1:0];
                CFG_STRIDE: r_cfg.row_stride   <= i_cfg_data[STRIDE_W-1:0];
                CFG_GCOUNT: r_cfg.group_count  <= i_cfg_data[GCNT_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    tga_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_coord0        (i_coord0),
        .i_coord1        (i_coord1),
        .i_coord2        (i_coord2),
        .i_coord3        (i_coord3),
        .i_coord_count   (i_coord_count),
        .i_element_bytes (i_element_bytes),
        .i_table_group   (i_table_group),
        .i_table_row     (i_table_row),
        .i_write_value   (i_write_value),
        .o_push          (w_push),
        .o_job           (w_push_job),
        .i_q_full        (w_full)
    );

    tga_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    tga_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_address    (o_address),
        .o_path_taken (o_path_taken)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("Job pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("Job popped from an empty queue.");

    a_path_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_path_taken == PATH_FLAT || o_path_taken == PATH_GROUP
                     || o_path_taken == PATH_OVF))
        else $error("Undefined path code on the output.");

    a_ovf_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_path_taken == PATH_OVF) |-> (o_address == r_cfg.base_address))
        else $error("Group overflow did not return the tensor base address.");
`endif

endmodule
